FILE: rtl/prf_pkg.sv
// ----------------------------------------------------------------------------
// prf_pkg: shared definitions for the parallel recursive filter bank
// Default parameter values, operation and coefficient slot codes, fixed-point
// widths and the tag that travels with each product through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package prf_pkg;

  // Default values for the top-level parameters.
  localparam int MAX_SECTIONS_DEF   = 8;
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 30;

  // Fixed-point formats of the section datapath.
  localparam int COEF_BITS = 32;
  localparam int Y_BITS    = 48;
  localparam int Y_FRAC    = 16;
  localparam int TERM_BITS = 58;  // holds the clamp range of +-2^56
  localparam int OUT_BITS  = 32;

  // Item operation codes.
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // Coefficient slots within one section.
  localparam logic [1:0] SLOT_F0 = 2'd0;
  localparam logic [1:0] SLOT_F1 = 2'd1;
  localparam logic [1:0] SLOT_G1 = 2'd2;
  localparam logic [1:0] SLOT_G2 = 2'd3;

  // Control tag that follows one partial product down the datapath.
  typedef struct packed {
    logic valid;    // stage holds a live product
    logic ph;       // 0: upper half of the operand, 1: lower half
    logic sec_end;  // last product of a section
    logic last;     // last product of the whole sample
  } tag_t;

endpackage

`default_nettype wire

FILE: rtl/parallel_recursive_filter_bank_core.sv
// ----------------------------------------------------------------------------
// parallel_recursive_filter_bank_core: parallel-form recursive filter bank
// Up to MAX_SECTIONS second-order sections share one input sample; their
// outputs are summed, rounded and saturated to a 32-bit result.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries items: tuser[0] selects filter (0) or coefficient
//   load (1), tuser[1] is the record-start flag that clears all history. A
//   load transaction writes one Q2.30 coefficient and returns no result; the
//   block is ready again in the next cycle. A filter transaction yields one
//   result on the master stream: tdata is the saturated sum and tuser the
//   clipping flag.
//   A filter item with N active sections needs four terms per section, each
//   term two passes through the single 32 x 33 multiplier, and then drains
//   through the datapath. The block accepts no item while a sample is being
//   processed. The result sits in an output register, so the next item may
//   be accepted while it waits; a stalled receiver only holds the block once
//   the next result is ready to be written. Reset clears the history, the
//   previous sample and the output valid and sets the active section count
//   to one; coefficients must be loaded before use. cfg_we writes the active
//   section count; the user must assert it only while the block is idle, as
//   the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module parallel_recursive_filter_bank_core #(
  parameter int MAX_SECTIONS   = prf_pkg::MAX_SECTIONS_DEF,
  parameter int SAMPLE_BITS    = prf_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = prf_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // Configuration: active section count.
  input  wire logic                                  cfg_we,
  input  wire logic [3:0]                            cfg_data,
  // Input stream.
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  // s_tdata from bit 0: sample, section_index, coef_index, coef_value, zeros
  input  wire logic [((SAMPLE_BITS+44)/8)*8-1:0]     s_tdata,
  // s_tuser from bit 0: operation, record_start
  input  wire logic [1:0]                            s_tuser,
  // Output stream.
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  // m_tdata from bit 0: output_sum
  output logic [prf_pkg::OUT_BITS-1:0]               m_tdata,
  // m_tuser from bit 0: clipped
  output logic                                       m_tuser
);

  import prf_pkg::*;

  localparam int SEC_W   = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int NW      = $clog2(MAX_SECTIONS + 1);
  localparam int DEPTH   = MAX_SECTIONS * 4;
  localparam int AW      = $clog2(DEPTH);
  localparam int SUM_W   = Y_BITS + $clog2(MAX_SECTIONS) + 1;
  localparam int ACC_W   = TERM_BITS + 2;
  localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'(48'sh7FFF_FFFF_FFFF);
  localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - ACC_W'(1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  state_t                    state_q;
  logic [3:0]                active_q;
  logic [NW-1:0]             n_q;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [SAMPLE_BITS-1:0] prev_q;
  logic signed [Y_BITS-1:0]  last_q  [MAX_SECTIONS];
  logic signed [Y_BITS-1:0]  older_q [MAX_SECTIONS];

  // Input field views.
  logic                          in_accept;
  logic                          in_op;
  logic                          in_rs;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic [2:0]                    in_section;
  logic [1:0]                    in_slot;
  logic [COEF_BITS-1:0]          in_coef;
  logic                          ld_we;
  logic                          filt;
  logic [NW-1:0]                 n_next;

  // Issue sequencer.
  logic [SEC_W-1:0]     k_q;
  logic [1:0]           t_q;
  logic                 ph_q;
  logic                 last_issue;
  logic signed [Y_BITS-1:0] v_sel;
  logic signed [32:0]   op_q;
  tag_t                 tag_i_q;
  logic [COEF_BITS-1:0] coef_rd;

  // Accumulate and write-back.
  logic signed [TERM_BITS-1:0] term;
  tag_t                        tag_c;
  logic signed [ACC_W-1:0]     acc_q;
  logic signed [ACC_W-1:0]     acc_next;
  logic signed [ACC_W-1:0]     ysum_q;
  tag_t                        tag_s;
  logic [SEC_W-1:0]            wb_k;
  logic signed [Y_BITS-1:0]    y_sat;
  logic                        y_clip;
  logic signed [SUM_W-1:0]     sum_q;
  logic                        clip_q;

  // Final rounding.
  logic                        out_free;
  logic signed [SUM_W:0]       rnd;
  logic signed [SUM_W-16:0]    rs;
  logic [OUT_BITS-1:0]         res;
  logic                        res_clip;

  // Field unpacking and acceptance.
  assign s_tready   = (state_q == ST_IDLE);
  assign in_accept  = s_tvalid & s_tready;
  assign in_op      = s_tuser[0];
  assign in_rs      = s_tuser[1];
  assign in_sample  = s_tdata[SAMPLE_BITS-1:0];
  assign in_section = s_tdata[SAMPLE_BITS+2:SAMPLE_BITS];
  assign in_slot    = s_tdata[SAMPLE_BITS+4:SAMPLE_BITS+3];
  assign in_coef    = s_tdata[SAMPLE_BITS+36:SAMPLE_BITS+5];
  assign ld_we      = in_accept && (in_op == OP_LOAD) && (32'(in_section) < MAX_SECTIONS);
  assign filt       = in_accept && (in_op == OP_FILTER);
  assign n_next     = (32'(active_q) > MAX_SECTIONS) ? NW'(MAX_SECTIONS) : NW'(active_q);
  assign last_issue = (32'(k_q) == 32'(n_q) - 1) && (t_q == SLOT_G2) && ph_q;
  assign out_free   = !m_tvalid || m_tready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_q <= 4'd1;
    end else if (cfg_we) begin
      active_q <= cfg_data;
    end
  end

  // Coefficient store.
  prf_ram #(
    .WIDTH (COEF_BITS),
    .DEPTH (DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (ld_we),
    .waddr (AW'({in_section, in_slot})),
    .wdata (in_coef),
    .raddr (AW'({k_q, t_q})),
    .rdata (coef_rd)
  );

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (filt) begin
            state_q <= (n_next == '0) ? ST_FIN : ST_RUN;
          end
        end
        ST_RUN: begin
          if (last_issue) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (tag_s.valid && tag_s.last) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Sample capture and issue counters.
  always_ff @(posedge clk) begin
    if (filt) begin
      x_q <= in_sample;
      n_q <= n_next;
    end
    if (rst || filt) begin
      k_q  <= '0;
      t_q  <= SLOT_F0;
      ph_q <= 1'b0;
    end else if (state_q == ST_RUN) begin
      ph_q <= ~ph_q;
      if (ph_q) begin
        t_q <= t_q + 2'd1;
        if (t_q == SLOT_G2) begin
          k_q <= k_q + SEC_W'(1);
        end
      end
    end
  end

  // Operand for the current term: both inputs in Q.16, then the history.
  always_comb begin
    case (t_q)
      SLOT_F0: v_sel = Y_BITS'(x_q) <<< Y_FRAC;
      SLOT_F1: v_sel = Y_BITS'(prev_q) <<< Y_FRAC;
      SLOT_G1: v_sel = last_q[k_q];
      default: v_sel = older_q[k_q];
    endcase
  end

  // Issue register, aligned with the coefficient read.
  always_ff @(posedge clk) begin
    op_q <= ph_q ? $signed({17'b0, v_sel[15:0]}) : $signed({v_sel[47], v_sel[47:16]});
    if (rst) begin
      tag_i_q <= '0;
    end else begin
      tag_i_q.valid   <= (state_q == ST_RUN);
      tag_i_q.ph      <= ph_q;
      tag_i_q.sec_end <= (t_q == SLOT_G2) && ph_q;
      tag_i_q.last    <= last_issue;
    end
  end

  prf_term_unit #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_term (
    .clk     (clk),
    .rst     (rst),
    .coef    (coef_rd),
    .operand (op_q),
    .tag_in  (tag_i_q),
    .term    (term),
    .tag_out (tag_c)
  );

  // Accumulate the four terms of one section.
  assign acc_next = acc_q + ACC_W'(term);

  always_ff @(posedge clk) begin
    if (tag_c.valid && tag_c.sec_end) begin
      ysum_q <= acc_next;
    end
    if (rst || filt) begin
      acc_q <= '0;
    end else if (tag_c.valid) begin
      acc_q <= tag_c.sec_end ? '0 : acc_next;
    end
    if (rst) begin
      tag_s <= '0;
    end else begin
      tag_s       <= tag_c;
      tag_s.valid <= tag_c.valid & tag_c.sec_end;
    end
  end

  // Section saturation.
  always_comb begin
    y_clip = (ysum_q > Y_MAX) || (ysum_q < Y_MIN);
    if (ysum_q > Y_MAX) begin
      y_sat = Y_BITS'(Y_MAX);
    end else if (ysum_q < Y_MIN) begin
      y_sat = Y_BITS'(Y_MIN);
    end else begin
      y_sat = Y_BITS'(ysum_q);
    end
  end

  // Section write-back and output sum.
  always_ff @(posedge clk) begin
    if (rst || filt) begin
      wb_k   <= '0;
      sum_q  <= '0;
      clip_q <= 1'b0;
    end else if (tag_s.valid) begin
      wb_k   <= wb_k + SEC_W'(1);
      sum_q  <= sum_q + SUM_W'(y_sat);
      clip_q <= clip_q | y_clip;
    end
  end

  // History: cleared by reset or a record start, shifted on write-back.
  always_ff @(posedge clk) begin
    if (rst || (filt && in_rs)) begin
      for (int i = 0; i < MAX_SECTIONS; i++) begin
        last_q[i]  <= '0;
        older_q[i] <= '0;
      end
    end else if (tag_s.valid) begin
      last_q[wb_k]  <= y_sat;
      older_q[wb_k] <= last_q[wb_k];
    end
  end

  // Previous sample: taken over when the result is written.
  always_ff @(posedge clk) begin
    if (rst || (filt && in_rs)) begin
      prev_q <= '0;
    end else if ((state_q == ST_FIN) && out_free) begin
      prev_q <= x_q;
    end
  end

  // Round half up to an integer and saturate to 32 bits.
  always_comb begin
    rnd      = (SUM_W+1)'(sum_q) + (SUM_W+1)'(32'sd32768);
    rs       = rnd[SUM_W:16];
    res_clip = clip_q;
    if (64'(rs) > 64'sd2147483647) begin
      res      = 32'h7FFF_FFFF;
      res_clip = 1'b1;
    end else if (64'(rs) < -64'sd2147483648) begin
      res      = 32'h8000_0000;
      res_clip = 1'b1;
    end else begin
      res = OUT_BITS'(rs);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if ((state_q == ST_FIN) && out_free) begin
      m_tdata <= res;
      m_tuser <= res_clip;
    end
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state_q == ST_FIN) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // The last write-back leaves nothing behind it in the datapath.
  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    (tag_s.valid && tag_s.last) |-> (!tag_c.valid && !tag_i_q.valid))
    else $error("products still in flight after the last section");

  // Write-back never runs past the active section count.
  a_wb_bound: assert property (@(posedge clk) disable iff (rst)
    tag_s.valid |-> (32'(wb_k) < 32'(n_q)))
    else $error("section write-back beyond the active count");

  // A new result appears only from the final state.
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state_q == ST_FIN))
    else $error("result raised outside the final state");

  // The block takes items only with an empty datapath.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!tag_i_q.valid && !tag_c.valid && !tag_s.valid))
    else $error("input accepted while the datapath is busy");

endmodule

`default_nettype wire

FILE: rtl/prf_ram.sv
// ----------------------------------------------------------------------------
// prf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module prf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/prf_term_unit.sv
// ----------------------------------------------------------------------------
// prf_term_unit: shared coefficient multiplier and term reduction
// Each term c*v is formed from two partial products, c times the upper 32 bits
// of v and c times its lower 16 bits, then reduced to a clamped Q.16 term.
// ----------------------------------------------------------------------------
`default_nettype none

module prf_term_unit #(
  parameter int COEF_FRAC_BITS = prf_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic        [prf_pkg::COEF_BITS-1:0]  coef,
  input  wire logic signed [32:0]                    operand,
  input  wire prf_pkg::tag_t                         tag_in,
  output logic signed      [prf_pkg::TERM_BITS-1:0]  term,
  output prf_pkg::tag_t                              tag_out
);

  import prf_pkg::*;

  localparam int KH = (COEF_FRAC_BITS >= Y_FRAC) ? COEF_FRAC_BITS - Y_FRAC : 0;
  localparam int KL = (COEF_FRAC_BITS < Y_FRAC) ? Y_FRAC - COEF_FRAC_BITS : 0;
  localparam logic signed [65:0] TERM_HI = 66'sd1 <<< 56;
  localparam logic signed [65:0] TERM_LO = -TERM_HI;
  localparam logic signed [65:0] AH_HI   = 66'sd1 <<< 52;
  localparam logic signed [65:0] AH_LO   = -AH_HI;

  logic signed [64:0] prod_q;
  tag_t               tag_m;
  logic signed [63:0] a_q;
  logic signed [48:0] b_s;
  logic signed [63:0] ah;
  logic signed [63:0] a_lo;
  logic signed [65:0] ah_w;
  logic signed [65:0] ah_c;
  logic signed [65:0] lo_sum;
  logic signed [65:0] hi_r;
  logic signed [65:0] a_w;
  logic signed [65:0] lo_r;
  logic signed [65:0] r_w;
  logic signed [65:0] r_c;

  // Multiply stage: one 32 x 33 signed product per cycle.
  always_ff @(posedge clk) begin
    prod_q <= $signed(coef) * operand;
    if (rst) begin
      tag_m <= '0;
    end else begin
      tag_m <= tag_in;
    end
  end

  // Reduction of the two partial products into one term, flooring exactly.
  always_comb begin
    b_s    = prod_q[48:0];
    // Upper product split into the part above and below the fraction point.
    ah     = a_q >>> KH;
    a_lo   = a_q - (ah <<< KH);
    ah_w   = 66'(ah);
    ah_c   = (ah_w > TERM_HI) ? TERM_HI : ((ah_w < TERM_LO) ? TERM_LO : ah_w);
    lo_sum = (66'(a_lo) <<< Y_FRAC) + 66'(b_s);
    hi_r   = ah_c + (lo_sum >>> COEF_FRAC_BITS);
    // Narrow fraction formats scale the upper product up instead.
    a_w    = 66'(a_q);
    lo_r   = (((a_w > AH_HI) ? AH_HI : ((a_w < AH_LO) ? AH_LO : a_w)) <<< KL)
             + (66'(b_s) >>> COEF_FRAC_BITS);
    r_w    = (COEF_FRAC_BITS >= Y_FRAC) ? hi_r : lo_r;
    r_c    = (r_w > TERM_HI) ? TERM_HI : ((r_w < TERM_LO) ? TERM_LO : r_w);
  end

  // Reduction stage: hold the upper product, emit a term with the lower one.
  always_ff @(posedge clk) begin
    if (tag_m.valid && !tag_m.ph) begin
      a_q <= prod_q[63:0];
    end
    if (tag_m.valid && tag_m.ph) begin
      term <= TERM_BITS'(r_c);
    end
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out       <= tag_m;
      tag_out.valid <= tag_m.valid & tag_m.ph;
    end
  end

endmodule

`default_nettype wire

FILE: sim/parallel_recursive_filter_bank_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// parallel_recursive_filter_bank_core_test: self-checking bench for the bank
// Loads coefficient words and streams samples through the core under several
// active section counts. A fixed-point model of the bank predicts every sum
// and clip flag, and each result is checked against it. Both streams idle at
// random, and the receiver stalls once for long enough to back up the input.
// ----------------------------------------------------------------------------

module parallel_recursive_filter_bank_core_test;

  localparam int SECTIONS     = prf_pkg::MAX_SECTIONS_DEF;
  localparam int X_BITS       = prf_pkg::SAMPLE_BITS_DEF;
  localparam int FRAC         = prf_pkg::COEF_FRAC_BITS_DEF;
  localparam int TDATA_BITS   = ((X_BITS + 44) / 8) * 8;
  localparam int DRAIN_CYCLES = 8 * SECTIONS + 16;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 150;
  localparam longint Y_HI = (longint'(1) <<< (prf_pkg::Y_BITS - 1)) - 1;
  localparam longint Y_LO = -(longint'(1) <<< (prf_pkg::Y_BITS - 1));
  localparam longint SUM_HI = 64'sd2147483647;
  localparam longint SUM_LO = -64'sd2147483648;

  // One filter result: saturated sum and clip flag.
  typedef struct packed {
    logic [prf_pkg::OUT_BITS-1:0] total;
    logic                         clip;
  } bank_out_t;

  // One row of the directed plan; typed rows carry their own expected result.
  typedef struct packed {
    logic        op;
    logic [23:0] sample;
    logic        restart;
    logic [2:0]  sec;
    logic [1:0]  slot;
    logic [31:0] coef;
    logic        typed;
    logic [31:0] total;
    logic        clip;
  } plan_row_t;

  localparam plan_row_t PLAN [25] = '{
    // Unity gain through f0 only.
    '{prf_pkg::OP_LOAD,   24'h000000, 1'b0, 3'd0, prf_pkg::SLOT_F0, 32'h4000_0000,
      1'b0, 32'd0, 1'b0},
    '{prf_pkg::OP_LOAD,   24'h000000, 1'b0, 3'd0, prf_pkg::SLOT_F1, 32'h0000_0000,
      1'b0, 32'd0, 1'b0},
    '{prf_pkg::OP_LOAD,   24'h000000, 1'b0, 3'd0, prf_pkg::SLOT_G1, 32'h0000_0000,
      1'b0, 32'd0, 1'b0},
    '{prf_pkg::OP_LOAD,   24'h000000, 1'b0, 3'd0, prf_pkg::SLOT_G2, 32'h0000_0000,
      1'b0, 32'd0, 1'b0},
    '{prf_pkg::OP_FILTER, 24'h7FFFFF, 1'b1, 3'd0, prf_pkg::SLOT_F0, 32'h0000_0000,
      1'b1, 32'sd8388607, 1'b0},
    '{prf_pkg::OP_FILTER, 24'h800000, 1'b0, 3'd0, prf_pkg::SLOT_F0, 32'h0000_0000,
      1'b1, -32'sd8388608, 1'b0},
    '{prf_pkg::OP_FILTER, 24'h000000, 1'b0, 3'd0, prf_pkg::SLOT_F0, 32'h0000_0000,
      1'b1, 32'sd0, 1'b0},
    '{prf_pkg::OP_FILTER, 24'h000004, 1'b0, 3'd0, prf_pkg::SLOT_F0, 32'h0000_0000,
      1'b1, 32'sd4, 1'b0},
    // A load ignores its sample and record-start flag and keeps the history.
    '{prf_pkg::OP_LOAD,   24'h7FFFFF, 1'b1, 3'd0, prf_pkg::SLOT_F1, 32'h4000_0000,
      1'b0, 32'd0, 1'b0},
    '{prf_pkg::OP_FILTER, 24'h000005, 1'b0, 3'd0, prf_pkg::SLOT_F0, 32'h0000_0000,
      1'b1, 32'sd9, 1'b0},
    '{prf_pkg::OP_FILTER, -24'sd3,    1'b0, 3'd0, prf_pkg::SLOT_F0, 32'h0000_0000,
      1'b1, 32'sd2, 1'b0},
    '{prf_pkg::OP_FILTER, 24'h000007, 1'b1, 3'd0, prf_pkg::SLOT_F0, 32'h0000_0000,
      1'b1, 32'sd7, 1'b0},
    // Extreme coefficients: the section runs away and saturates.
    '{prf_pkg::OP_LOAD,   24'h000000, 1'b0, 3'd0, prf_pkg::SLOT_F0, 32'h7FFF_FFFF,
      1'b0, 32'd0, 1'b0},
    '{prf_pkg::OP_LOAD,   24'h000000, 1'b0, 3'd0, prf_pkg::SLOT_F1, 32'h8000_0000,
      1'b0, 32'd0, 1'b0},
    '{prf_pkg::OP_LOAD,   24'h000000, 1'b0, 3'd0, prf_pkg::SLOT_G1, 32'h7FFF_FFFF,
      1'b0, 32'd0, 1'b0},
    '{prf_pkg::OP_LOAD,   24'h000000, 1'b0, 3'd0, prf_pkg::SLOT_G2, 32'h7FFF_FFFF,
      1'b0, 32'd0, 1'b0},
    '{prf_pkg::OP_FILTER, 24'h7FFFFF, 1'b1, 3'd0, prf_pkg::SLOT_F0, 32'h0000_0000,
      1'b0, 32'd0, 1'b0},
    '{prf_pkg::OP_FILTER, 24'h7FFFFF, 1'b0, 3'd0, prf_pkg::SLOT_F0, 32'h0000_0000,
      1'b0, 32'd0, 1'b0},
    '{prf_pkg::OP_FILTER, 24'h7FFFFF, 1'b0, 3'd0, prf_pkg::SLOT_F0, 32'h0000_0000,
      1'b0, 32'd0, 1'b0},
    '{prf_pkg::OP_FILTER, 24'h7FFFFF, 1'b0, 3'd0, prf_pkg::SLOT_F0, 32'h0000_0000,
      1'b0, 32'd0, 1'b0},
    '{prf_pkg::OP_FILTER, 24'h7FFFFF, 1'b0, 3'd0, prf_pkg::SLOT_F0, 32'h0000_0000,
      1'b0, 32'd0, 1'b0},
    '{prf_pkg::OP_FILTER, 24'h7FFFFF, 1'b0, 3'd0, prf_pkg::SLOT_F0, 32'h0000_0000,
      1'b0, 32'd0, 1'b0},
    '{prf_pkg::OP_FILTER, 24'h7FFFFF, 1'b0, 3'd0, prf_pkg::SLOT_F0, 32'h0000_0000,
      1'b0, 32'd0, 1'b0},
    '{prf_pkg::OP_FILTER, 24'h7FFFFF, 1'b0, 3'd0, prf_pkg::SLOT_F0, 32'h0000_0000,
      1'b1, 32'h7FFF_FFFF, 1'b1},
    '{prf_pkg::OP_FILTER, 24'h800000, 1'b1, 3'd0, prf_pkg::SLOT_F0, 32'h0000_0000,
      1'b0, 32'd0, 1'b0}
  };

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [3:0]                    cfg_data;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [TDATA_BITS-1:0]         s_tdata;
  logic [1:0]                    s_tuser;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [prf_pkg::OUT_BITS-1:0]  m_tdata;
  logic                          m_tuser;

  // Predicted bank state and the sums still to come.
  logic [31:0]              coef_bank [SECTIONS*4];
  logic signed [X_BITS-1:0] prior_x;
  longint                   recent_y [SECTIONS];
  longint                   older_y [SECTIONS];
  logic [3:0]               sections_in_use;
  bank_out_t                expected_sums [$];
  int                       items_sent;
  int                       mismatches;

  parallel_recursive_filter_bank_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Exact floor of coefficient times value over the coefficient scale.
  function automatic longint coef_times(logic signed [31:0] c, longint v);
    logic signed [95:0] wide;
    wide = c;
    wide = (wide * v) >>> FRAC;
    return longint'(wide);
  endfunction

  // Runs one sample through every active section and forms the rounded sum.
  function automatic bank_out_t predict_sample(logic signed [X_BITS-1:0] x,
                                               logic restart);
    bank_out_t r;
    longint    y;
    longint    total;
    longint    rounded;
    longint    xq;
    longint    pq;
    int        n;
    int        k;
    logic      clip;
    if (restart) begin
      prior_x = '0;
      for (k = 0; k < SECTIONS; k++) begin
        recent_y[k] = 0;
        older_y[k]  = 0;
      end
    end
    clip  = 1'b0;
    total = 0;
    n     = (sections_in_use > SECTIONS) ? SECTIONS : int'(sections_in_use);
    xq    = longint'(x) <<< prf_pkg::Y_FRAC;
    pq    = longint'(prior_x) <<< prf_pkg::Y_FRAC;
    for (k = 0; k < n; k++) begin
      y = coef_times($signed(coef_bank[4*k + int'(prf_pkg::SLOT_F0)]), xq)
        + coef_times($signed(coef_bank[4*k + int'(prf_pkg::SLOT_F1)]), pq)
        + coef_times($signed(coef_bank[4*k + int'(prf_pkg::SLOT_G1)]), recent_y[k])
        + coef_times($signed(coef_bank[4*k + int'(prf_pkg::SLOT_G2)]), older_y[k]);
      if (y > Y_HI) begin
        y    = Y_HI;
        clip = 1'b1;
      end else if (y < Y_LO) begin
        y    = Y_LO;
        clip = 1'b1;
      end
      older_y[k]  = recent_y[k];
      recent_y[k] = y;
      total       = total + y;
    end
    prior_x = x;
    rounded = (total + (longint'(1) <<< (prf_pkg::Y_FRAC - 1))) >>> prf_pkg::Y_FRAC;
    if (rounded > SUM_HI) begin
      rounded = SUM_HI;
      clip    = 1'b1;
    end else if (rounded < SUM_LO) begin
      rounded = SUM_LO;
      clip    = 1'b1;
    end
    r.total = rounded[31:0];
    r.clip  = clip;
    return r;
  endfunction

  // Prints one mismatch line, up to a cap, and counts every one.
  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch on %s at %0t: got %h, expected %h", field, $time, got, want);
    end
  endtask

  // Offers one item, waits for the transaction and records what it should give.
  task automatic offer_item(logic op, logic [23:0] sample, logic restart,
                            logic [2:0] sec, logic [1:0] slot, logic [31:0] coef,
                            logic typed, logic [31:0] lit_total, logic lit_clip);
    bank_out_t predicted;
    if (!(items_sent >= 400 && items_sent < 700) && $urandom_range(0, 99) < 15) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < 40) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= TDATA_BITS'({coef, slot, sec, sample});
    s_tuser  <= {restart, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (op == prf_pkg::OP_LOAD) begin
      coef_bank[{sec, slot}] = coef;
    end else begin
      predicted = predict_sample($signed(sample), restart);
      if (typed) begin
        predicted.total = lit_total;
        predicted.clip  = lit_clip;
      end
      expected_sums.push_back(predicted);
    end
  endtask

  // Lets every outstanding sum arrive, then waits out a further drain period.
  task automatic settle_bank();
    s_tvalid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes the active section count while the bank is idle.
  task automatic set_section_count(logic [3:0] count);
    settle_bank();
    cfg_we   <= 1'b1;
    cfg_data <= count;
    @(posedge clk);
    cfg_we          <= 1'b0;
    sections_in_use = count;
  endtask

  // A random item: mostly samples of mixed size, some coefficient loads.
  task automatic random_item();
    logic [31:0] coef;
    logic [23:0] x;
    logic        restart;
    int          pick;
    pick    = $urandom_range(0, 99);
    restart = ($urandom_range(0, 99) < 5);
    x       = 24'($urandom);
    if ($urandom_range(0, 99) < 65) begin
      coef = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
    end else begin
      coef = $urandom;
    end
    if (pick < 12) begin
      offer_item(prf_pkg::OP_LOAD, x, restart, 3'($urandom), 2'($urandom), coef,
                 1'b0, 32'd0, 1'b0);
    end else begin
      if (pick < 37) begin
        x = 24'($urandom_range(0, 2000)) - 24'd1000;
      end else if (pick < 50) begin
        x = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      end
      offer_item(prf_pkg::OP_FILTER, x, restart, 3'($urandom), 2'($urandom), coef,
                 1'b0, 32'd0, 1'b0);
    end
  endtask

  // Stimulus: reset, directed plan, coefficient preload, then random phases.
  initial begin : stimulus
    logic [3:0] counts [9];
    int         row;
    int         phase;
    int         n;
    counts     = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd1, 4'd9, 4'd6, 4'd8, 4'd0};
    counts[8]  = 4'($urandom_range(0, 15));
    items_sent = 0;
    mismatches = 0;
    rst      <= 1'b1;
    cfg_we   <= 1'b0;
    cfg_data <= 4'd0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    set_section_count(4'd1);

    for (row = 0; row < 25; row++) begin
      offer_item(PLAN[row].op, PLAN[row].sample, PLAN[row].restart, PLAN[row].sec,
                 PLAN[row].slot, PLAN[row].coef, PLAN[row].typed, PLAN[row].total,
                 PLAN[row].clip);
    end

    // Fill every coefficient with a stable value before more sections are enabled.
    for (n = 0; n < SECTIONS * 4; n++) begin
      offer_item(prf_pkg::OP_LOAD, 24'($urandom), 1'($urandom), 3'(n / 4), 2'(n % 4),
                 $urandom_range(0, 32'h2000_0000) - 32'h1000_0000, 1'b0, 32'd0, 1'b0);
    end

    for (phase = 0; phase < 9; phase++) begin
      set_section_count(counts[phase]);
      for (n = 0; n < PHASE_ITEMS; n++) random_item();
    end

    settle_bank();
    if (mismatches == 0) begin
      $display("parallel_recursive_filter_bank_core_test: PASS");
    end else begin
      $display("parallel_recursive_filter_bank_core_test: FAIL");
    end
    $finish;
  end

  // Receiver: takes results with random back-pressure and one long hold-off.
  initial begin : receiver
    bank_out_t want;
    int        taken;
    logic      held;
    taken = 0;
    held  = 1'b0;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        taken++;
        if (expected_sums.size() == 0) begin
          report_mismatch("result with none pending", m_tdata, 32'd0);
        end else begin
          want = expected_sums.pop_front();
          if (m_tdata !== want.total) report_mismatch("output_sum", m_tdata, want.total);
          if (m_tuser !== want.clip) report_mismatch("clipped", 32'(m_tuser), 32'(want.clip));
        end
      end
      if (!held && taken >= 120) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= (taken >= 350 && taken < 650) || ($urandom_range(0, 99) >= 15);
    end
  end

  // Watchdog: ends the run when no transaction has happened for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("parallel_recursive_filter_bank_core_test: FAIL");
    $finish;
  end

endmodule
